FILE: rtl/rpn_pkg.sv
// Package for the RPN stack calculator: token codes, controller states, ALU
// op codes and the ALU request struct. No dependencies.
package rpn_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW = 4;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_POW  = 4'd5,
    OP_TERN = 4'd6,
    OP_SQRT = 4'd7,
    OP_LOG  = 4'd8,
    OP_END  = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    ALU_DIV,
    ALU_POW,
    ALU_SQRT,
    ALU_LOG
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t kind;
  } alu_req_t;

endpackage

FILE: rtl/rpn_alu.sv
// Multi-cycle unit for divide, power, integer square root and integer log.
// Depends on rpn_pkg. Operands must be legal; error checks live in the top.
module rpn_alu
  import rpn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output logic             done,
  output logic [DataW-1:0] res
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          kind_r, kind_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [DataW-1:0] x_r, x_nxt;     // dividend bits / exponent / sqrt arg / log arg
  logic [DataW-1:0] y_r, y_nxt;     // divisor / base / sqrt root / log base
  logic [DataW:0]   p_r, p_nxt;     // remainder
  logic [DataW-1:0] q_r, q_nxt;     // quotient / pow result / log count
  logic             neg_r, neg_nxt;
  logic [63:0]      lp_r, lp_nxt;   // running power for log

  logic [DataW-1:0] mag_a, mag_b;
  logic [DataW:0]   rem_sh, rem_sub;
  logic [DataW-1:0] root_t;
  logic [63:0]      sq_t, lp_mul;

  assign mag_a = a[DataW-1] ? (~a + 1'b1) : a;
  assign mag_b = b[DataW-1] ? (~b + 1'b1) : b;
  assign rem_sh = {p_r[DataW-1:0], x_r[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, y_r};
  assign root_t = y_r | (32'h0000_8000 >> cnt_r[3:0]);
  assign sq_t = {32'd0, root_t} * {32'd0, root_t};
  assign lp_mul = lp_r[DataW-1:0] * y_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    kind_nxt = kind_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r;
    y_nxt = y_r;
    p_nxt = p_r;
    q_nxt = q_r;
    neg_nxt = neg_r;
    lp_nxt = lp_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      kind_nxt = req.kind;
      cnt_nxt = '0;
      p_nxt = '0;
      q_nxt = '0;
      neg_nxt = a[DataW-1] ^ b[DataW-1];
      lp_nxt = {32'd0, b};
      case (req.kind)
        ALU_DIV: begin
          x_nxt = mag_a;
          y_nxt = mag_b;
        end
        ALU_POW: begin
          x_nxt = b;
          y_nxt = a;
          q_nxt = 32'd1;
        end
        ALU_SQRT: begin
          x_nxt = a;
          y_nxt = '0;
        end
        default: begin
          x_nxt = a;
          y_nxt = b;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      case (kind_r)
        ALU_DIV: begin
          // One restoring-division step per cycle.
          x_nxt = {x_r[DataW-2:0], 1'b0};
          if (!rem_sub[DataW]) begin
            p_nxt = rem_sub;
            q_nxt = {q_r[DataW-2:0], 1'b1};
          end else begin
            p_nxt = rem_sh;
            q_nxt = {q_r[DataW-2:0], 1'b0};
          end
          if (cnt_r == 6'd31) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            if (neg_r) q_nxt = ~q_nxt + 1'b1;
          end
        end
        ALU_POW: begin
          // Square-and-multiply: even steps multiply the result, odd steps square the base.
          if (!cnt_r[0]) begin
            if (x_r[0]) q_nxt = q_r * y_r;
          end else begin
            y_nxt = y_r * y_r;
            x_nxt = x_r >> 1;
          end
          if (cnt_r == 6'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        ALU_SQRT: begin
          if (sq_t <= {32'd0, x_r}) y_nxt = root_t;
          if (cnt_r == 6'd15) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            q_nxt = (sq_t <= {32'd0, x_r}) ? root_t : y_r;
          end
        end
        default: begin
          // Base is at least 2, so the running power passes any 32-bit argument.
          if (lp_r <= {32'd0, x_r}) begin
            q_nxt = q_r + 1'b1;
            lp_nxt = lp_mul;
          end else begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    kind_r <= kind_nxt;
    cnt_r <= cnt_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    p_r <= p_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
    lp_r <= lp_nxt;
  end

  assign done = done_r;
  assign res = q_r;

endmodule

FILE: rtl/rpn_stack_calculator.sv
// RPN stack calculator: stack in a one-port-write synchronous memory, one
// request at a time. A push writes the stack as it is accepted; other requests
// go through READ, FETCH and EXEC, then WAIT on rpn_alu for divide, power, sqrt
// and log, then WRITE. An end request sets the result in EXEC, or in IDLE if empty.
// A waiting result holds off only the next end request.
// Synchronous active-low reset empties the stack and clears the error flag;
// memory contents are not cleared.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OpW-1:0]    in_op,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] out_result,
  output logic              out_error
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DataW-1:0] mem [STACK_DEPTH];

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             err_r, err_nxt;
  op_t              op_r;
  logic [1:0]       ridx_r, ridx_nxt;
  logic [DataW-1:0] a_r, b_r, c_r;
  logic [DataW-1:0] rdata_r;
  logic [DataW-1:0] wdata_r, wdata_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DataW-1:0] out_res_r, out_res_nxt;
  logic             out_err_r, out_err_nxt;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic [1:0]       need;
  logic [CW-1:0]    pos;
  alu_req_t         alu_req;
  logic             alu_done;
  logic [DataW-1:0] alu_res;
  logic             accept;
  logic [DataW-1:0] prod;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !(out_valid_r && in_op == OP_END);
  assign need = (op_r == OP_TERN) ? 2'd3 : (op_r == OP_SQRT) ? 2'd1 : 2'd2;
  assign pos = count_r - CW'(ridx_r) - 1'b1;
  assign prod = a_r * b_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  rpn_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .a    (a_r),
    .b    (b_r),
    .done (alu_done),
    .res  (alu_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_PUSH || in_op > OP_END) state_nxt = ST_IDLE;
          else if (in_op == OP_END) state_nxt = (count_r == '0) ? ST_IDLE : ST_READ;
          else state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (op_r != OP_END && count_r < CW'(need)) state_nxt = ST_IDLE;
        else state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (op_r == OP_END || ridx_r == need) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_r == OP_END) state_nxt = ST_IDLE;
        else if (op_r == OP_DIV && b_r != '0) state_nxt = ST_WAIT;
        else if (op_r == OP_POW && !b_r[DataW-1]) state_nxt = ST_WAIT;
        else if (op_r == OP_SQRT && !a_r[DataW-1]) state_nxt = ST_WAIT;
        else if (op_r == OP_LOG && !a_r[DataW-1] && a_r != '0 && !b_r[DataW-1]
                 && b_r > 32'd1) state_nxt = ST_WAIT;
        else state_nxt = ST_WRITE;
      end
      ST_WAIT: begin
        if (alu_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    count_nxt = count_r;
    err_nxt = err_r;
    ridx_nxt = ridx_r;
    wdata_nxt = wdata_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt = out_res_r;
    out_err_nxt = out_err_r;
    rd_en = 1'b0;
    rd_addr = pos[AW-1:0];
    wr_en = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_value;
    alu_req.start = 1'b0;
    alu_req.kind = ALU_DIV;
    case (op_r)
      OP_POW:  alu_req.kind = ALU_POW;
      OP_SQRT: alu_req.kind = ALU_SQRT;
      OP_LOG:  alu_req.kind = ALU_LOG;
      default: alu_req.kind = ALU_DIV;
    endcase
    case (state_r)
      ST_IDLE: begin
        ridx_nxt = '0;
        if (accept) begin
          if (in_op == OP_PUSH) begin
            if (count_r >= CW'(STACK_DEPTH)) err_nxt = 1'b1;
            else begin
              wr_en = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (in_op > OP_END) begin
            err_nxt = 1'b1;
          end else if (in_op == OP_END && count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '0;
            out_err_nxt = 1'b1;
            err_nxt = 1'b0;
          end
        end
      end
      ST_READ: begin
        if (op_r != OP_END && count_r < CW'(need)) err_nxt = 1'b1;
        else begin
          rd_en = 1'b1;
          ridx_nxt = ridx_r + 2'd1;
        end
      end
      ST_FETCH: begin
        // One stack entry arrives per cycle; the next read overlaps.
        if (op_r != OP_END && ridx_r != need) begin
          rd_en = 1'b1;
          ridx_nxt = ridx_r + 2'd1;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_END) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = a_r;
          out_err_nxt = err_r;
          err_nxt = 1'b0;
          count_nxt = '0;
        end else begin
          alu_req.start = (state_nxt == ST_WAIT);
          wdata_nxt = '0;
          case (op_r)
            OP_ADD:  wdata_nxt = a_r + b_r;
            OP_SUB:  wdata_nxt = a_r - b_r;
            OP_MUL:  wdata_nxt = prod;
            OP_TERN: wdata_nxt = (a_r != '0) ? b_r : c_r;
            default: if (state_nxt != ST_WAIT) err_nxt = 1'b1;
          endcase
        end
      end
      ST_WAIT: begin
        if (alu_done) wdata_nxt = alu_res;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        wr_addr = AW'(count_r - CW'(need));
        wr_data = wdata_r;
        count_nxt = count_r - CW'(need) + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ridx_r <= ridx_nxt;
    wdata_r <= wdata_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
    if (accept) op_r <= op_t'(in_op);
    // Operand registers: a is top, b next, c third, in read order.
    if (state_r == ST_FETCH) begin
      case (ridx_r)
        2'd1: a_r <= rdata_r;
        2'd2: b_r <= rdata_r;
        default: c_r <= rdata_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_result = out_res_r;
  assign out_error = out_err_r;

endmodule
